@@ rtl/landslide_risk_alarm_macros.svh @@
// Assertion macros used by the landslide risk alarm top level.
`ifndef LANDSLIDE_RISK_ALARM_MACROS_SVH
`define LANDSLIDE_RISK_ALARM_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define LRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("landslide_risk_alarm: assertion failed");
// Next-cycle implication, disabled during reset.
`define LRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("landslide_risk_alarm: assertion failed");
`else
`define LRA_ASSERT_NOW(label, clk, rst, ante, cons)
`define LRA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/lra_pkg.sv @@
// Package: types, codes and defaults for the landslide risk alarm.
package lra_pkg;

   localparam int HISTORY_SLOTS_DEF = 10;
   localparam int CLEAR_PERIOD_DEF  = 60;

   localparam int READ_W   = 12;
   localparam int ANGLE_W  = 11;
   localparam int TILT_W   = 10;
   localparam int INTEN_W  = 4;
   localparam int TOTAL_W  = 6;
   localparam int LEVEL_W  = 2;
   localparam int LED_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_WARNING  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILT_CRITICAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOIL_ARID     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOIL_WET      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RAIN_CLEAR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAIN_LIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT         = 3'd7;

   // Register reset values
   localparam logic [TILT_W-1:0]  TILT_WARNING_RST  = 10'd150;
   localparam logic [TILT_W-1:0]  TILT_CRITICAL_RST = 10'd250;
   localparam logic [READ_W-1:0]  SOIL_ARID_RST     = 12'd3000;
   localparam logic [READ_W-1:0]  SOIL_WET_RST      = 12'd1200;
   localparam logic [READ_W-1:0]  RAIN_CLEAR_RST    = 12'd2800;
   localparam logic [READ_W-1:0]  RAIN_LIGHT_RST    = 12'd1800;
   localparam logic [INTEN_W-1:0] INTENSITY_RST     = 4'd3;
   localparam logic [TOTAL_W-1:0] COUNT_RST         = 6'd8;

   // Level codes
   localparam logic [LEVEL_W-1:0] ALERT_NORMAL   = 2'd0;
   localparam logic [LEVEL_W-1:0] ALERT_RAISED   = 2'd1;
   localparam logic [LEVEL_W-1:0] ALERT_CRITICAL = 2'd2;
   localparam logic [LEVEL_W-1:0] SOIL_PARCHED   = 2'd0;
   localparam logic [LEVEL_W-1:0] SOIL_MEDIUM    = 2'd1;
   localparam logic [LEVEL_W-1:0] SOIL_WET       = 2'd2;
   localparam logic [LEVEL_W-1:0] RAIN_NONE      = 2'd0;
   localparam logic [LEVEL_W-1:0] RAIN_LIGHT     = 2'd1;
   localparam logic [LEVEL_W-1:0] RAIN_HEAVY     = 2'd2;

   localparam logic [LED_W-1:0] LED_GREEN  = 3'b001;
   localparam logic [LED_W-1:0] LED_YELLOW = 3'b010;
   localparam logic [LED_W-1:0] LED_RED    = 3'b100;

   typedef struct packed {
      logic [TILT_W-1:0]  tilt_warning;
      logic [TILT_W-1:0]  tilt_critical;
      logic [READ_W-1:0]  soil_arid;
      logic [READ_W-1:0]  soil_wet;
      logic [READ_W-1:0]  rain_clear;
      logic [READ_W-1:0]  rain_light;
      logic [INTEN_W-1:0] intensity;
      logic [TOTAL_W-1:0] count;
   } cfg_type;

   typedef struct packed {
      logic               rise;
      logic [INTEN_W-1:0] intensity;
      logic [TOTAL_W-1:0] total;
   } vib_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] risk_grade;
      logic [LEVEL_W-1:0] soil_level;
      logic [LEVEL_W-1:0] rain_grade;
      logic               vibration_edge;
      logic [INTEN_W-1:0] shake_intensity;
      logic [TOTAL_W-1:0] vibration_total;
      logic [LED_W-1:0]   led_drive;
   } res_type;

endpackage

@@ rtl/lra_csr.sv @@
// Threshold register bank with reset defaults.
module lra_csr import lra_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TILT_WARNING:  cfg_in.tilt_warning  = csr_wdata[TILT_W-1:0];
            CSR_TILT_CRITICAL: cfg_in.tilt_critical = csr_wdata[TILT_W-1:0];
            CSR_SOIL_ARID:     cfg_in.soil_arid     = csr_wdata[READ_W-1:0];
            CSR_SOIL_WET:      cfg_in.soil_wet      = csr_wdata[READ_W-1:0];
            CSR_RAIN_CLEAR:    cfg_in.rain_clear    = csr_wdata[READ_W-1:0];
            CSR_RAIN_LIGHT:    cfg_in.rain_light    = csr_wdata[READ_W-1:0];
            CSR_INTENSITY:     cfg_in.intensity     = csr_wdata[INTEN_W-1:0];
            CSR_COUNT:         cfg_in.count         = csr_wdata[TOTAL_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tilt_warning  <= TILT_WARNING_RST;
         cfg_ff.tilt_critical <= TILT_CRITICAL_RST;
         cfg_ff.soil_arid     <= SOIL_ARID_RST;
         cfg_ff.soil_wet      <= SOIL_WET_RST;
         cfg_ff.rain_clear    <= RAIN_CLEAR_RST;
         cfg_ff.rain_light    <= RAIN_LIGHT_RST;
         cfg_ff.intensity     <= INTENSITY_RST;
         cfg_ff.count         <= COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/lra_track.sv @@
// Vibration tracker: edge detect, slot ring, running total and clear period.
module lra_track import lra_pkg::*; #(
   parameter int HISTORY_SLOTS = HISTORY_SLOTS_DEF,
   parameter int CLEAR_PERIOD  = CLEAR_PERIOD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  logic    pin,
   output vib_type vib
);

   localparam int PtrW  = $clog2(HISTORY_SLOTS);
   localparam int CntW  = $clog2(HISTORY_SLOTS + 1);
   localparam int TickW = $clog2(CLEAR_PERIOD + 1);

   logic                     prev_pin_ff;
   logic [HISTORY_SLOTS-1:0] slots_ff, slots_in;
   logic [PtrW-1:0]          ptr_ff, ptr_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic [TickW-1:0]         tick_ff;
   logic                     rise;
   logic                     tick_last;
   logic [CntW-1:0]          cnt;

   always_comb begin
      rise     = pin & ~prev_pin_ff;
      slots_in = slots_ff;
      if (rise) begin
         slots_in[ptr_ff] = 1'b1;
      end
      ptr_in = (ptr_ff == PtrW'(HISTORY_SLOTS - 1)) ? '0 : PtrW'(ptr_ff + 1'b1);
      // the slot just entered starts empty
      slots_in[ptr_in] = 1'b0;
      cnt = '0;
      for (int i = 0; i < HISTORY_SLOTS; i++) begin
         cnt = CntW'(cnt + CntW'(slots_in[i]));
      end
      // saturate at the top count
      total_in  = (rise && total_ff != '1) ? TOTAL_W'(total_ff + 1'b1) : total_ff;
      tick_last = (tick_ff == TickW'(CLEAR_PERIOD - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pin_ff <= 1'b0;
         slots_ff    <= '0;
         ptr_ff      <= '0;
         total_ff    <= '0;
         tick_ff     <= '0;
      end else if (step) begin
         prev_pin_ff <= pin;
         slots_ff    <= slots_in;
         ptr_ff      <= ptr_in;
         total_ff    <= tick_last ? '0 : total_in;
         tick_ff     <= tick_last ? '0 : TickW'(tick_ff + 1'b1);
      end
   end

   always_comb begin
      vib.rise      = rise;
      vib.intensity = (int'(cnt) > 15) ? '1 : INTEN_W'(cnt);
      vib.total     = total_in;
   end

endmodule

@@ rtl/lra_grade.sv @@
// Grading and risk analysis: levels, alert and lamp drive.
module lra_grade import lra_pkg::*; (
   input  cfg_type                   cfg,
   input  vib_type                   vib,
   input  logic [READ_W-1:0]         soil_reading,
   input  logic [READ_W-1:0]         rain_reading,
   input  logic signed [ANGLE_W-1:0] pitch_tenths,
   input  logic signed [ANGLE_W-1:0] roll_tenths,
   output res_type                   res
);

   logic [ANGLE_W-1:0] abs_pitch, abs_roll, tilt;
   logic [LEVEL_W-1:0] soil_lvl, rain_lvl, alert;
   logic [2:0]         crit, warn;

   always_comb begin
      // magnitude of the most negative angle stays representable unsigned
      abs_pitch = pitch_tenths[ANGLE_W-1] ? ANGLE_W'(~pitch_tenths + 1'b1) : pitch_tenths;
      abs_roll  = roll_tenths[ANGLE_W-1]  ? ANGLE_W'(~roll_tenths + 1'b1)  : roll_tenths;
      tilt      = (abs_pitch > abs_roll) ? abs_pitch : abs_roll;

      if (soil_reading > cfg.soil_arid) begin
         soil_lvl = SOIL_PARCHED;
      end else if (soil_reading < cfg.soil_wet) begin
         soil_lvl = SOIL_WET;
      end else begin
         soil_lvl = SOIL_MEDIUM;
      end

      if (rain_reading >= cfg.rain_clear) begin
         rain_lvl = RAIN_NONE;
      end else if (rain_reading >= cfg.rain_light) begin
         rain_lvl = RAIN_LIGHT;
      end else begin
         rain_lvl = RAIN_HEAVY;
      end

      crit = '0;
      warn = '0;
      if (tilt >= ANGLE_W'(cfg.tilt_critical)) begin
         crit = crit + 3'd1;
      end else if (tilt >= ANGLE_W'(cfg.tilt_warning)) begin
         warn = warn + 3'd1;
      end
      if (rain_lvl == RAIN_HEAVY) begin
         crit = crit + 3'd1;
      end else if (rain_lvl == RAIN_LIGHT) begin
         warn = warn + 3'd1;
      end
      if (soil_lvl == SOIL_WET) begin
         crit = crit + 3'd1;
      end else if (soil_lvl == SOIL_PARCHED) begin
         warn = warn + 3'd1;
      end
      if (vib.intensity >= cfg.intensity) begin
         crit = crit + 3'd1;
      end else if (vib.total >= cfg.count) begin
         warn = warn + 3'd1;
      end

      if (crit >= 3'd2 || (crit >= 3'd1 && warn >= 3'd2)) begin
         alert = ALERT_CRITICAL;
      end else if (crit >= 3'd1 || warn >= 3'd2) begin
         alert = ALERT_RAISED;
      end else begin
         alert = ALERT_NORMAL;
      end

      res.risk_grade      = alert;
      res.soil_level      = soil_lvl;
      res.rain_grade      = rain_lvl;
      res.vibration_edge  = vib.rise;
      res.shake_intensity = vib.intensity;
      res.vibration_total = vib.total;
      case (alert)
         ALERT_CRITICAL: res.led_drive = LED_RED;
         ALERT_RAISED:   res.led_drive = LED_YELLOW;
         default:        res.led_drive = LED_GREEN;
      endcase
   end

endmodule

@@ rtl/landslide_risk_alarm.sv @@
// Landslide risk alarm top level: input register, tracker and grading, result register.
// A request beat is held in the input register and graded; the result register loads
// its grade when that register is free, and the result is then offered.
// Throughput: one beat per cycle while the result side does not stall; the single input
// register and result register let a new request enter while a result waits under stall.
// Reset (synchronous): thresholds return to defaults, vibration history and
// counters clear, both pipeline stages empty.
`include "landslide_risk_alarm_macros.svh"

module landslide_risk_alarm import lra_pkg::*; #(
   parameter int HISTORY_SLOTS = HISTORY_SLOTS_DEF,
   parameter int CLEAR_PERIOD  = CLEAR_PERIOD_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [READ_W-1:0]         req_soil_reading,
   input  logic [READ_W-1:0]         req_rain_reading,
   input  logic                      req_vibration_pin,
   input  logic signed [ANGLE_W-1:0] req_pitch_tenths,
   input  logic signed [ANGLE_W-1:0] req_roll_tenths,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LEVEL_W-1:0]        rsp_risk_grade,
   output logic [LEVEL_W-1:0]        rsp_soil_level,
   output logic [LEVEL_W-1:0]        rsp_rain_grade,
   output logic                      rsp_vibration_edge,
   output logic [INTEN_W-1:0]        rsp_shake_intensity,
   output logic [TOTAL_W-1:0]        rsp_vibration_total,
   output logic [LED_W-1:0]          rsp_led_drive,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   cfg_type cfg;
   vib_type vib;
   res_type res, res_ff;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [READ_W-1:0]         soil_ff, rain_ff;
   logic                      pin_ff;
   logic signed [ANGLE_W-1:0] pitch_ff, roll_ff;
   logic                      advance, req_take, step;

   // the result register frees when empty or when its beat is taken
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;
   assign step      = s1_valid_ff & advance;

   always_comb begin
      s1_valid_in  = req_take | (s1_valid_ff & ~advance);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         soil_ff  <= req_soil_reading;
         rain_ff  <= req_rain_reading;
         pin_ff   <= req_vibration_pin;
         pitch_ff <= req_pitch_tenths;
         roll_ff  <= req_roll_tenths;
      end
      if (step) begin
         res_ff <= res;
      end
   end

   lra_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lra_track #(
      .HISTORY_SLOTS (HISTORY_SLOTS),
      .CLEAR_PERIOD  (CLEAR_PERIOD)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .pin   (pin_ff),
      .vib   (vib)
   );

   lra_grade u_grade (
      .cfg          (cfg),
      .vib          (vib),
      .soil_reading (soil_ff),
      .rain_reading (rain_ff),
      .pitch_tenths (pitch_ff),
      .roll_tenths  (roll_ff),
      .res          (res)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_risk_grade      = res_ff.risk_grade;
   assign rsp_soil_level      = res_ff.soil_level;
   assign rsp_rain_grade      = res_ff.rain_grade;
   assign rsp_vibration_edge  = res_ff.vibration_edge;
   assign rsp_shake_intensity = res_ff.shake_intensity;
   assign rsp_vibration_total = res_ff.vibration_total;
   assign rsp_led_drive       = res_ff.led_drive;

   `LRA_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff && rsp_stall)
   `LRA_ASSERT_NOW(a_led_onehot, clock, reset, rsp_valid, $onehot(rsp_led_drive))
   `LRA_ASSERT_NOW(a_red_is_critical, clock, reset, rsp_valid, rsp_led_drive[2] == (rsp_risk_grade == ALERT_CRITICAL))
   `LRA_ASSERT_NEXT(a_step_fills_result, clock, reset, step, rsp_valid_ff)

endmodule

@@ sim/tb_landslide_risk_alarm.sv @@
// Self-checking testbench for the landslide risk alarm: directed ticks, random ticks, scoreboard.
`timescale 1ns / 100ps

module tb_landslide_risk_alarm;
   import lra_pkg::*;

   localparam int CLK_PERIOD      = 20;
   localparam int RESET_CYCLES    = 6;
   localparam int DRAIN_CYCLES    = 4;
   localparam int ITEMS_PER_SET   = 82;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DIRECTED_ROWS   = 22;

   typedef struct packed {
      logic [READ_W-1:0]         soil;
      logic [READ_W-1:0]         rain;
      logic                      pin;
      logic signed [ANGLE_W-1:0] pitch;
      logic signed [ANGLE_W-1:0] roll;
   } tick_type;

   typedef struct packed {
      tick_type tick;
      logic     typed;
      res_type  want;
   } row_type;

   typedef enum {SET_DEFAULT, SET_MILLIVOLT, SET_FLOOR, SET_CEILING, SET_CROSSED, SET_RANDOM}
      setting_type;

   localparam res_type NO_GRADE = '0;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [READ_W-1:0]         req_soil_reading;
   logic [READ_W-1:0]         req_rain_reading;
   logic                      req_vibration_pin;
   logic signed [ANGLE_W-1:0] req_pitch_tenths;
   logic signed [ANGLE_W-1:0] req_roll_tenths;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [LEVEL_W-1:0]        rsp_risk_grade;
   logic [LEVEL_W-1:0]        rsp_soil_level;
   logic [LEVEL_W-1:0]        rsp_rain_grade;
   logic                      rsp_vibration_edge;
   logic [INTEN_W-1:0]        rsp_shake_intensity;
   logic [TOTAL_W-1:0]        rsp_vibration_total;
   logic [LED_W-1:0]          rsp_led_drive;
   logic                      csr_write;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   // Model of the alarm: thresholds and vibration history
   cfg_type                      limits;
   logic                         pin_seen;
   logic [HISTORY_SLOTS_DEF-1:0] edge_ring;
   int                           ring_pos;
   logic [TOTAL_W-1:0]           edge_count;
   int                           ticks_in_period;

   res_type pending_grades [$];
   int      mismatch_count;
   bit      steady_run;

   setting_type plan [8] = '{SET_DEFAULT, SET_MILLIVOLT, SET_FLOOR, SET_CEILING, SET_CROSSED,
                             SET_RANDOM, SET_RANDOM, SET_RANDOM};

   // soil, rain, pin, pitch, roll, typed, then the typed grade where there is one
   row_type directed_rows [DIRECTED_ROWS] = '{
      {12'd2000, 12'd3000, 1'b0, 11'sd0, 11'sd0,
       1'b1, ALERT_NORMAL, SOIL_MEDIUM, RAIN_NONE, 1'b0, 4'd0, 6'd0, LED_GREEN},
      {12'd4095, 12'd4095, 1'b1, 11'sd900, 11'sd0,
       1'b1, ALERT_RAISED, SOIL_PARCHED, RAIN_NONE, 1'b1, 4'd1, 6'd1, LED_YELLOW},
      {12'd0, 12'd0, 1'b1, -11'sd900, 11'h400,
       1'b1, ALERT_CRITICAL, SOIL_WET, RAIN_HEAVY, 1'b0, 4'd1, 6'd1, LED_RED},
      {12'd3000, 12'd2800, 1'b0, 11'sd149, -11'sd149,
       1'b1, ALERT_NORMAL, SOIL_MEDIUM, RAIN_NONE, 1'b0, 4'd1, 6'd1, LED_GREEN},
      {12'd1200, 12'd2799, 1'b1, 11'sd150, 11'sd0,
       1'b1, ALERT_RAISED, SOIL_MEDIUM, RAIN_LIGHT, 1'b1, 4'd2, 6'd2, LED_YELLOW},
      {12'd3001, 12'd1800, 1'b0, 11'sd249, 11'sd0,
       1'b1, ALERT_RAISED, SOIL_PARCHED, RAIN_LIGHT, 1'b0, 4'd2, 6'd2, LED_YELLOW},
      {12'd1199, 12'd1799, 1'b1, 11'sd0, 11'sd250,
       1'b1, ALERT_CRITICAL, SOIL_WET, RAIN_HEAVY, 1'b1, 4'd3, 6'd3, LED_RED},
      {12'd2500, 12'd2000, 1'b0, 11'sd1023, 11'sd0, 1'b0, NO_GRADE},
      {12'd1500, 12'd1000, 1'b1, -11'sd1, 11'sd1023, 1'b0, NO_GRADE},
      {12'd4095, 12'd4095, 1'b0, 11'h400, 11'h400, 1'b0, NO_GRADE},
      {12'd0, 12'd0, 1'b1, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd1300, 12'd2900, 1'b0, 11'sd200, -11'sd200, 1'b0, NO_GRADE},
      {12'd2900, 12'd2900, 1'b1, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd2000, 1'b0, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b1, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b0, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b1, -11'sd250, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b1, 11'sd0, -11'sd150, 1'b0, NO_GRADE},
      {12'hAAA, 12'h555, 1'b0, 11'h2AA, 11'h555, 1'b0, NO_GRADE},
      {12'h555, 12'hAAA, 1'b1, 11'h555, 11'h2AA, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b0, 11'sd0, 11'sd0, 1'b0, NO_GRADE},
      {12'd2000, 12'd3500, 1'b1, 11'sd0, 11'sd0, 1'b0, NO_GRADE}
   };

   landslide_risk_alarm dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_soil_reading    (req_soil_reading),
      .req_rain_reading    (req_rain_reading),
      .req_vibration_pin   (req_vibration_pin),
      .req_pitch_tenths    (req_pitch_tenths),
      .req_roll_tenths     (req_roll_tenths),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_risk_grade      (rsp_risk_grade),
      .rsp_soil_level      (rsp_soil_level),
      .rsp_rain_grade      (rsp_rain_grade),
      .rsp_vibration_edge  (rsp_vibration_edge),
      .rsp_shake_intensity (rsp_shake_intensity),
      .rsp_vibration_total (rsp_vibration_total),
      .rsp_led_drive       (rsp_led_drive),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   function automatic void restore_defaults();
      limits.tilt_warning  = TILT_WARNING_RST;
      limits.tilt_critical = TILT_CRITICAL_RST;
      limits.soil_arid     = SOIL_ARID_RST;
      limits.soil_wet      = SOIL_WET_RST;
      limits.rain_clear    = RAIN_CLEAR_RST;
      limits.rain_light    = RAIN_LIGHT_RST;
      limits.intensity     = INTENSITY_RST;
      limits.count         = COUNT_RST;
      pin_seen        = 1'b0;
      edge_ring       = '0;
      ring_pos        = 0;
      edge_count      = '0;
      ticks_in_period = 0;
   endfunction

   // Keep only the register's own width of the written data
   function automatic void store_limit(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TILT_WARNING:  limits.tilt_warning  = data[TILT_W-1:0];
         CSR_TILT_CRITICAL: limits.tilt_critical = data[TILT_W-1:0];
         CSR_SOIL_ARID:     limits.soil_arid     = data[READ_W-1:0];
         CSR_SOIL_WET:      limits.soil_wet      = data[READ_W-1:0];
         CSR_RAIN_CLEAR:    limits.rain_clear    = data[READ_W-1:0];
         CSR_RAIN_LIGHT:    limits.rain_light    = data[READ_W-1:0];
         CSR_INTENSITY:     limits.intensity     = data[INTEN_W-1:0];
         CSR_COUNT:         limits.count         = data[TOTAL_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the vibration history by one tick and grade it
   function automatic res_type grade_tick(input tick_type t);
      res_type           g;
      logic [ANGLE_W-1:0] mag_pitch, mag_roll, tilt;
      int                hits, crit, warn;
      crit = 0;
      warn = 0;
      g.vibration_edge = t.pin & ~pin_seen;
      pin_seen = t.pin;
      if (g.vibration_edge) begin
         if (edge_count != '1) edge_count++;
         edge_ring[ring_pos] = 1'b1;
      end
      ring_pos = (ring_pos == HISTORY_SLOTS_DEF - 1) ? 0 : ring_pos + 1;
      edge_ring[ring_pos] = 1'b0;
      hits = 0;
      for (int s = 0; s < HISTORY_SLOTS_DEF; s++) hits += edge_ring[s];
      if (hits > 15) hits = 15;
      g.shake_intensity = INTEN_W'(hits);
      g.vibration_total = edge_count;

      if (t.soil > limits.soil_arid) g.soil_level = SOIL_PARCHED;
      else if (t.soil < limits.soil_wet) g.soil_level = SOIL_WET;
      else g.soil_level = SOIL_MEDIUM;

      if (t.rain >= limits.rain_clear) g.rain_grade = RAIN_NONE;
      else if (t.rain >= limits.rain_light) g.rain_grade = RAIN_LIGHT;
      else g.rain_grade = RAIN_HEAVY;

      // magnitude of the most negative angle stays 1024, above any threshold
      mag_pitch = t.pitch[ANGLE_W-1] ? ANGLE_W'(-t.pitch) : ANGLE_W'(t.pitch);
      mag_roll  = t.roll[ANGLE_W-1] ? ANGLE_W'(-t.roll) : ANGLE_W'(t.roll);
      tilt = (mag_pitch > mag_roll) ? mag_pitch : mag_roll;

      if (tilt >= {1'b0, limits.tilt_critical}) crit++;
      else if (tilt >= {1'b0, limits.tilt_warning}) warn++;
      if (g.rain_grade == RAIN_HEAVY) crit++;
      else if (g.rain_grade == RAIN_LIGHT) warn++;
      if (g.soil_level == SOIL_WET) crit++;
      else if (g.soil_level == SOIL_PARCHED) warn++;
      if (g.shake_intensity >= limits.intensity) crit++;
      else if (edge_count >= limits.count) warn++;

      if (crit >= 2 || (crit >= 1 && warn >= 2)) g.risk_grade = ALERT_CRITICAL;
      else if (crit >= 1 || warn >= 2) g.risk_grade = ALERT_RAISED;
      else g.risk_grade = ALERT_NORMAL;
      g.led_drive = (g.risk_grade == ALERT_CRITICAL) ? LED_RED :
                    (g.risk_grade == ALERT_RAISED) ? LED_YELLOW : LED_GREEN;

      ticks_in_period++;
      if (ticks_in_period >= CLEAR_PERIOD_DEF) begin
         edge_count = '0;
         ticks_in_period = 0;
      end
      return g;
   endfunction

   // Mostly short, now and then a long one
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (steady_run || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [READ_W-1:0] pick_reading(input logic [READ_W-1:0] upper,
                                                      input logic [READ_W-1:0] lower);
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 4) return READ_W'($urandom);
      if (mode < 6) return upper + READ_W'($urandom_range(0, 4)) - READ_W'(2);
      if (mode < 8) return lower + READ_W'($urandom_range(0, 4)) - READ_W'(2);
      return (mode == 8) ? '0 : '1;
   endfunction

   function automatic logic signed [ANGLE_W-1:0] pick_angle();
      int mode, mag;
      mode = $urandom_range(0, 9);
      if (mode < 5) return ANGLE_W'(int'($urandom_range(0, 1800)) - 900);
      if (mode < 8) begin
         mag = int'(mode == 5 ? limits.tilt_warning : limits.tilt_critical)
               + int'($urandom_range(0, 2)) - 1;
         return ANGLE_W'($urandom_range(0, 1) ? -mag : mag);
      end
      if (mode == 8) return ANGLE_W'($urandom);
      case ($urandom_range(0, 3))
         0: return 11'h400;
         1: return 11'sd1023;
         2: return -11'sd900;
         default: return 11'sd900;
      endcase
   endfunction

   // Mostly toggle the pin so that edges come often enough to fill the window
   function automatic tick_type random_tick();
      tick_type t;
      t.soil  = pick_reading(limits.soil_arid, limits.soil_wet);
      t.rain  = pick_reading(limits.rain_clear, limits.rain_light);
      t.pin   = ($urandom_range(0, 9) < 6) ? ~pin_seen : 1'($urandom_range(0, 1));
      t.pitch = pick_angle();
      t.roll  = pick_angle();
      return t;
   endfunction

   task automatic send_tick(input tick_type t, input logic typed, input res_type want);
      res_type graded;
      repeat (pick_pause()) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_soil_reading  <= t.soil;
      req_rain_reading  <= t.rain;
      req_vibration_pin <= t.pin;
      req_pitch_tenths  <= t.pitch;
      req_roll_tenths   <= t.roll;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      graded = grade_tick(t);
      pending_grades.push_back(typed ? want : graded);
   endtask

   // Hold off until every grade is back and the pipeline is empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_grades.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      store_limit(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic program_limits(input setting_type setting);
      case (setting)
         SET_MILLIVOLT: begin
            write_limit(CSR_TILT_WARNING, 12'd100);
            write_limit(CSR_TILT_CRITICAL, 12'd200);
            write_limit(CSR_SOIL_ARID, 12'd2500);
            write_limit(CSR_SOIL_WET, 12'd800);
            write_limit(CSR_RAIN_CLEAR, 12'd2500);
            write_limit(CSR_RAIN_LIGHT, 12'd1500);
            write_limit(CSR_INTENSITY, 12'd2);
            write_limit(CSR_COUNT, 12'd5);
         end
         SET_CROSSED: begin
            write_limit(CSR_TILT_WARNING, 12'd400);
            write_limit(CSR_TILT_CRITICAL, 12'd100);
            write_limit(CSR_SOIL_ARID, 12'd1000);
            write_limit(CSR_SOIL_WET, 12'd3000);
            write_limit(CSR_RAIN_CLEAR, 12'd1000);
            write_limit(CSR_RAIN_LIGHT, 12'd3000);
            write_limit(CSR_INTENSITY, 12'd4);
            write_limit(CSR_COUNT, 12'd2);
         end
         SET_FLOOR, SET_CEILING, SET_RANDOM: begin
            // the ceiling writes all ones, so the narrow registers drop the upper bits
            for (int r = CSR_TILT_WARNING; r <= CSR_COUNT; r++)
               write_limit(CSR_IDX_W'(r), (setting == SET_FLOOR) ? '0 :
                           (setting == SET_CEILING) ? '1 : CSR_DATA_W'($urandom));
         end
         default: ;
      endcase
   endtask

   // Result side: random stalls
   initial begin
      int hold_cycles;
      hold_cycles = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles == 0 && $urandom_range(0, 3) == 0) hold_cycles = pick_pause();
         if (steady_run) hold_cycles = 0;
         rsp_stall <= (hold_cycles != 0);
         if (hold_cycles != 0) hold_cycles--;
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_grades.size() == 0) begin
            $error("result beat with no grade expected");
            mismatch_count++;
         end else begin
            want = pending_grades.pop_front();
            if (rsp_risk_grade !== want.risk_grade) begin
               $error("risk_grade: expected %0d, got %0d", want.risk_grade, rsp_risk_grade);
               mismatch_count++;
            end
            if (rsp_soil_level !== want.soil_level) begin
               $error("soil_level: expected %0d, got %0d", want.soil_level, rsp_soil_level);
               mismatch_count++;
            end
            if (rsp_rain_grade !== want.rain_grade) begin
               $error("rain_grade: expected %0d, got %0d", want.rain_grade, rsp_rain_grade);
               mismatch_count++;
            end
            if (rsp_vibration_edge !== want.vibration_edge) begin
               $error("vibration_edge: expected %0d, got %0d", want.vibration_edge,
                      rsp_vibration_edge);
               mismatch_count++;
            end
            if (rsp_shake_intensity !== want.shake_intensity) begin
               $error("shake_intensity: expected %0d, got %0d", want.shake_intensity,
                      rsp_shake_intensity);
               mismatch_count++;
            end
            if (rsp_vibration_total !== want.vibration_total) begin
               $error("vibration_total: expected %0d, got %0d", want.vibration_total,
                      rsp_vibration_total);
               mismatch_count++;
            end
            if (rsp_led_drive !== want.led_drive) begin
               $error("led_drive: expected %0d, got %0d", want.led_drive, rsp_led_drive);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_soil_reading  = '0;
      req_rain_reading  = '0;
      req_vibration_pin = 1'b0;
      req_pitch_tenths  = '0;
      req_roll_tenths   = '0;
      csr_write         = 1'b0;
      csr_index         = CSR_TILT_WARNING;
      csr_wdata         = '0;
      steady_run        = 1'b0;
      mismatch_count    = 0;
      restore_defaults();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
      settle();

      foreach (plan[p]) begin
         program_limits(plan[p]);
         for (int n = 0; n < ITEMS_PER_SET; n++) begin
            // one back-to-back stretch per setting
            steady_run = (n >= 30 && n < 45);
            send_tick(random_tick(), 1'b0, NO_GRADE);
         end
         steady_run = 1'b0;
         settle();
      end

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lra_pkg.sv
rtl/lra_csr.sv
rtl/lra_track.sv
rtl/lra_grade.sv
rtl/landslide_risk_alarm.sv
sim/tb_landslide_risk_alarm.sv
